// ----- src/fohtu_pkg.sv -----
// Shared constants, types and codes of the frequency-ordered history table.
package fohtu_pkg;

  localparam int unsigned DEPTH    = 64;
  localparam int unsigned KEY_BITS = 32;
  localparam int unsigned KEY_W    = (KEY_BITS < 32) ? KEY_BITS : 32;
  localparam int unsigned IDX_W    = $clog2(DEPTH);
  localparam int unsigned CNT_W    = $clog2(DEPTH + 1);
  localparam int unsigned USE_W    = 32;
  localparam logic [USE_W-1:0] USE_MAX = '1;

  typedef enum logic [1:0] {
    KIND_ADD    = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_READ   = 2'd2,
    KIND_IGNORE = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_RANGE     = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_PLAN,
    S_WRITE,
    S_DONE
  } state_e;

  typedef enum logic [1:0] {
    WM_NONE,
    WM_BUMP,
    WM_REMOVE,
    WM_APPEND
  } mode_e;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [USE_W-1:0] uses;
  } entry_t;

  typedef struct packed {
    logic   shift;
    entry_t wr;
  } ring_ctl_t;

endpackage

// ----- src/fohtu_cell.sv -----
// One storage cell of the rotating table ring.
module fohtu_cell (
  input  logic              clk_i,
  input  logic              shift_i,
  input  fohtu_pkg::entry_t nxt_i,
  output fohtu_pkg::entry_t ent_o
);
  import fohtu_pkg::*;

  entry_t ent_q;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      ent_q <= nxt_i;
    end
  end

  assign ent_o = ent_q;

endmodule

// ----- src/fohtu_ctrl.sv -----
// Sequencer that scans the ring, plans the update, rewrites the ring when the table changes and holds the result.
module fohtu_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [1:0]           kind_i,
  input  logic [31:0]          key_i,
  input  logic [5:0]           index_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [1:0]           status_o,
  output logic [5:0]           rank_o,
  output logic [31:0]          entry_key_o,
  output logic [31:0]          entry_uses_o,
  output logic [6:0]           entries_in_use_o,
  input  fohtu_pkg::entry_t    tap_i,
  output fohtu_pkg::ring_ctl_t ring_o
);
  import fohtu_pkg::*;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] step_q;
  logic [CNT_W-1:0] valid_q;
  logic             found_q;
  logic             out_valid_q;

  kind_e            kind_q;
  logic [KEY_W-1:0] key_q;
  logic [5:0]       idx_q;
  logic [IDX_W-1:0] pos_q, dst_q, run_q;
  logic [USE_W-1:0] cnt_q, prev_q;
  entry_t           rd_q, h1_q, h2_q;
  mode_e            mode_q;
  logic [1:0]       res_status_q;
  logic [5:0]       res_rank_q;
  logic [31:0]      res_key_q, res_uses_q;
  logic [1:0]       out_status_q;
  logic [5:0]       out_rank_q;
  logic [31:0]      out_key_q, out_uses_q;
  logic [6:0]       out_count_q;

  logic             accept, last_scan, last_write, hit, deliver;
  logic [IDX_W-1:0] step_idx, run_now, wr_idx, dst_fix;
  logic [CNT_W-1:0] wr_pos;
  logic [USE_W-1:0] cnt_inc;
  entry_t           new_ent;

  mode_e            plan_mode;
  status_e          plan_status;
  logic [5:0]       plan_rank;
  logic [31:0]      plan_key, plan_uses;
  logic [IDX_W-1:0] plan_pos;
  logic [CNT_W-1:0] plan_valid;

  assign accept     = in_valid_i && in_ready_o;
  assign deliver    = !out_valid_q || out_ready_i;
  assign last_scan  = (step_q == CNT_W'(DEPTH - 1));
  assign last_write = (step_q == CNT_W'(DEPTH));
  assign step_idx   = step_q[IDX_W-1:0];
  assign wr_pos     = step_q - CNT_W'(1);
  assign wr_idx     = wr_pos[IDX_W-1:0];
  assign hit        = !found_q && (step_q < valid_q) && (tap_i.key == key_q);
  assign run_now    = ((step_q == '0) || (tap_i.uses != prev_q)) ? step_idx : run_q;
  assign cnt_inc    = (cnt_q == USE_MAX) ? cnt_q : cnt_q + USE_W'(1);
  assign dst_fix    = (cnt_q == USE_MAX) ? pos_q : dst_q;
  assign new_ent    = '{key: key_q, uses: res_uses_q};

  always_comb begin
    plan_mode   = WM_NONE;
    plan_status = ST_OK;
    plan_rank   = '0;
    plan_key    = '0;
    plan_uses   = '0;
    plan_pos    = pos_q;
    plan_valid  = valid_q;
    case (kind_q)
      KIND_ADD: begin
        plan_key = 32'(key_q);
        if (found_q) begin
          plan_mode = WM_BUMP;
          plan_rank = 6'(dst_fix);
          plan_uses = cnt_inc;
        end else if (valid_q == CNT_W'(DEPTH)) begin
          plan_status = ST_FULL;
        end else begin
          plan_mode  = WM_APPEND;
          plan_pos   = valid_q[IDX_W-1:0];
          plan_rank  = 6'(valid_q);
          plan_uses  = 32'd1;
          plan_valid = valid_q + CNT_W'(1);
        end
      end
      KIND_REMOVE: begin
        plan_key = 32'(key_q);
        if (found_q) begin
          plan_mode  = WM_REMOVE;
          plan_rank  = 6'(pos_q);
          plan_uses  = cnt_q;
          plan_valid = valid_q - CNT_W'(1);
        end else begin
          plan_status = ST_NOT_FOUND;
        end
      end
      KIND_READ: begin
        plan_rank = idx_q;
        if (32'(idx_q) < 32'(valid_q)) begin
          plan_key  = 32'(rd_q.key);
          plan_uses = rd_q.uses;
        end else begin
          plan_status = ST_RANGE;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (in_valid_i) state_d = S_SCAN;
      S_SCAN:  if (last_scan) state_d = S_PLAN;
      S_PLAN:  state_d = (plan_mode != WM_NONE) ? S_WRITE : S_DONE;
      S_WRITE: if (last_write) state_d = S_DONE;
      S_DONE:  if (deliver) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o   = (state_q == S_IDLE);
    ring_o.shift = (state_q == S_SCAN) || (state_q == S_WRITE);
    ring_o.wr    = tap_i;
    if ((state_q == S_WRITE) && (step_q != '0)) begin
      ring_o.wr = h1_q;
      case (mode_q)
        WM_BUMP: begin
          if (wr_idx == dst_q) begin
            ring_o.wr = new_ent;
          end else if ((wr_idx > dst_q) && (wr_idx <= pos_q)) begin
            ring_o.wr = h2_q;
          end
        end
        WM_REMOVE: begin
          if (wr_idx >= pos_q) begin
            ring_o.wr = tap_i;
          end
        end
        WM_APPEND: begin
          if (wr_idx == pos_q) begin
            ring_o.wr = new_ent;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= '0;
      valid_q     <= '0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        step_q  <= '0;
        found_q <= 1'b0;
      end
      if (state_q == S_SCAN) begin
        step_q <= last_scan ? '0 : step_q + CNT_W'(1);
        if (hit) begin
          found_q <= 1'b1;
        end
      end
      if (state_q == S_PLAN) begin
        step_q  <= '0;
        valid_q <= plan_valid;
      end
      if (state_q == S_WRITE) begin
        step_q <= step_q + CNT_W'(1);
      end
      if ((state_q == S_DONE) && deliver) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q <= kind_e'(kind_i);
      key_q  <= key_i[KEY_W-1:0];
      idx_q  <= index_i;
    end
    if (state_q == S_SCAN) begin
      prev_q <= tap_i.uses;
      run_q  <= run_now;
      if (32'(step_q) == 32'(idx_q)) begin
        rd_q <= tap_i;
      end
      if (hit) begin
        pos_q <= step_idx;
        dst_q <= run_now;
        cnt_q <= tap_i.uses;
      end
    end
    if (state_q == S_PLAN) begin
      mode_q       <= plan_mode;
      pos_q        <= plan_pos;
      dst_q        <= dst_fix;
      res_status_q <= plan_status;
      res_rank_q   <= plan_rank;
      res_key_q    <= plan_key;
      res_uses_q   <= plan_uses;
    end
    if (state_q == S_WRITE) begin
      h1_q <= tap_i;
      h2_q <= h1_q;
    end
    if ((state_q == S_DONE) && deliver) begin
      out_status_q <= res_status_q;
      out_rank_q   <= res_rank_q;
      out_key_q    <= res_key_q;
      out_uses_q   <= res_uses_q;
      out_count_q  <= 7'(valid_q);
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_status_q;
  assign rank_o           = out_rank_q;
  assign entry_key_o      = out_key_q;
  assign entry_uses_o     = out_uses_q;
  assign entries_in_use_o = out_count_q;

`ifndef SYNTHESIS
  a_valid_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q <= CNT_W'(DEPTH))
    else $error("entry count exceeds table depth");

  a_hit_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PLAN && found_q) |-> (CNT_W'(pos_q) < valid_q))
    else $error("hit position lies beyond the valid entries");

  a_bump_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WRITE && mode_q == WM_BUMP) |-> (dst_q <= pos_q))
    else $error("bumped entry would move backward");

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !in_ready_o)
    else $error("second transaction accepted while one is in flight");

  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PLAN && plan_status == ST_FULL) |-> (valid_q == CNT_W'(DEPTH)))
    else $error("full status reported on a table with free entries");
`endif

endmodule

// ----- src/frequency_ordered_history_table_unit.sv -----
// Top level of the frequency-ordered history table: a rotating ring of cells and its sequencer.
//
//   Channel   Handshake                 Payload
//   input     in_valid_i / in_ready_o   kind_i, key_i, index_i
//   output    out_valid_o / out_ready_i status_o, rank_o, entry_key_o, entry_uses_o,
//                                       entries_in_use_o
//
// Each transaction rotates the ring of DEPTH cells one cell per cycle in a scan pass;
// add and remove hits and appends add a rewrite pass, in which the table changes.
// One transaction is in flight at a time; the result register lets the next item start
// while the previous result waits, and the sequencer holds when that register is full.
// Reset empties the table at once; cell contents need no clearing.
module frequency_ordered_history_table_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  kind_i,
  input  logic [31:0] key_i,
  input  logic [5:0]  index_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [5:0]  rank_o,
  output logic [31:0] entry_key_o,
  output logic [31:0] entry_uses_o,
  output logic [6:0]  entries_in_use_o
);
  import fohtu_pkg::*;

  entry_t    cell_ent [DEPTH];
  ring_ctl_t ring;

  fohtu_ctrl u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .kind_i           (kind_i),
    .key_i            (key_i),
    .index_i          (index_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .status_o         (status_o),
    .rank_o           (rank_o),
    .entry_key_o      (entry_key_o),
    .entry_uses_o     (entry_uses_o),
    .entries_in_use_o (entries_in_use_o),
    .tap_i            (cell_ent[0]),
    .ring_o           (ring)
  );

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    if (g == DEPTH - 1) begin : g_tail
      fohtu_cell u_cell (
        .clk_i   (clk_i),
        .shift_i (ring.shift),
        .nxt_i   (ring.wr),
        .ent_o   (cell_ent[g])
      );
    end else begin : g_body
      fohtu_cell u_cell (
        .clk_i   (clk_i),
        .shift_i (ring.shift),
        .nxt_i   (cell_ent[g+1]),
        .ent_o   (cell_ent[g])
      );
    end
  end

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for the frequency-ordered history table unit.
`timescale 1ns / 1ps

module tb;
  import fohtu_pkg::*;

  typedef struct packed {
    status_e     status;
    logic [5:0]  rank;
    logic [31:0] key;
    logic [31:0] uses;
    logic [6:0]  count;
  } history_result_t;

  typedef struct packed {
    kind_e           kind;
    logic [31:0]     key;
    logic [5:0]      idx;
    bit              typed;
    history_result_t want;
  } probe_row_t;

  typedef enum {
    PH_FILL,
    PH_CHURN,
    PH_DRAIN
  } traffic_e;

  localparam int RANDOM_ITEMS   = 785;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 2 * DEPTH + 8;

  localparam history_result_t NO_RESULT = '0;

  localparam probe_row_t DIRECTED_ROWS [24] = '{
    '{KIND_READ,   32'h0000_0000, 6'd0,  1'b1, '{ST_RANGE, 6'd0, 32'h0, 32'd0, 7'd0}},
    '{KIND_READ,   32'h0000_0000, 6'd63, 1'b1, '{ST_RANGE, 6'd63, 32'h0, 32'd0, 7'd0}},
    '{KIND_REMOVE, 32'hFFFF_FFFF, 6'd0,  1'b1,
      '{ST_NOT_FOUND, 6'd0, 32'hFFFF_FFFF, 32'd0, 7'd0}},
    '{KIND_ADD,    32'h0000_0000, 6'd0,  1'b1, '{ST_OK, 6'd0, 32'h0, 32'd1, 7'd1}},
    '{KIND_ADD,    32'hFFFF_FFFF, 6'd0,  1'b1, '{ST_OK, 6'd1, 32'hFFFF_FFFF, 32'd1, 7'd2}},
    '{KIND_ADD,    32'hFFFF_FFFF, 6'd0,  1'b1, '{ST_OK, 6'd0, 32'hFFFF_FFFF, 32'd2, 7'd2}},
    '{KIND_IGNORE, 32'hA5A5_A5A5, 6'd42, 1'b1, '{ST_OK, 6'd0, 32'h0, 32'd0, 7'd2}},
    '{KIND_ADD,    32'h8000_0000, 6'd0,  1'b1, '{ST_OK, 6'd2, 32'h8000_0000, 32'd1, 7'd3}},
    '{KIND_ADD,    32'h0000_0001, 6'd0,  1'b1, '{ST_OK, 6'd3, 32'h1, 32'd1, 7'd4}},
    '{KIND_ADD,    32'h0000_0001, 6'd0,  1'b1, '{ST_OK, 6'd1, 32'h1, 32'd2, 7'd4}},
    '{KIND_ADD,    32'h0000_0001, 6'd0,  1'b1, '{ST_OK, 6'd0, 32'h1, 32'd3, 7'd4}},
    '{KIND_READ,   32'h0000_0000, 6'd1,  1'b1, '{ST_OK, 6'd1, 32'hFFFF_FFFF, 32'd2, 7'd4}},
    '{KIND_REMOVE, 32'h0000_0000, 6'd0,  1'b1, '{ST_OK, 6'd2, 32'h0, 32'd1, 7'd3}},
    '{KIND_REMOVE, 32'h8000_0000, 6'd0,  1'b1, '{ST_OK, 6'd2, 32'h8000_0000, 32'd1, 7'd2}},
    '{KIND_REMOVE, 32'h0000_0001, 6'd0,  1'b1, '{ST_OK, 6'd0, 32'h1, 32'd3, 7'd1}},
    '{KIND_READ,   32'h0000_0000, 6'd0,  1'b1, '{ST_OK, 6'd0, 32'hFFFF_FFFF, 32'd2, 7'd1}},
    '{KIND_READ,   32'h0000_0000, 6'd1,  1'b1, '{ST_RANGE, 6'd1, 32'h0, 32'd0, 7'd1}},
    '{KIND_REMOVE, 32'hFFFF_FFFF, 6'd0,  1'b1, '{ST_OK, 6'd0, 32'hFFFF_FFFF, 32'd2, 7'd0}},
    '{KIND_ADD,    32'h5A5A_5A5A, 6'd0,  1'b0, NO_RESULT},
    '{KIND_ADD,    32'h5A5A_5A5A, 6'd0,  1'b0, NO_RESULT},
    '{KIND_ADD,    32'h3C3C_3C3C, 6'd0,  1'b0, NO_RESULT},
    '{KIND_READ,   32'h0000_0000, 6'd2,  1'b0, NO_RESULT},
    '{KIND_IGNORE, 32'hFFFF_FFFF, 6'd63, 1'b1, '{ST_OK, 6'd0, 32'h0, 32'd0, 7'd2}},
    '{KIND_REMOVE, 32'h5A5A_5A5A, 6'd0,  1'b0, NO_RESULT}
  };

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  logic [1:0]  kind_i      = KIND_ADD;
  logic [31:0] key_i       = '0;
  logic [5:0]  index_i     = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  status_o;
  logic [5:0]  rank_o;
  logic [31:0] entry_key_o;
  logic [31:0] entry_uses_o;
  logic [6:0]  entries_in_use_o;

  logic [31:0] table_key  [DEPTH];
  logic [31:0] table_uses [DEPTH];
  int          table_used;

  history_result_t expected_q [$];
  bit              steady;
  int              mismatch_count;
  int              results_checked;
  int              transactions_sent;
  int              stall_cycles;
  int              full_seen;
  int              miss_seen;
  int              range_seen;
  int              peak_used;

  frequency_ordered_history_table_unit DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .kind_i           (kind_i),
    .key_i            (key_i),
    .index_i          (index_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .status_o         (status_o),
    .rank_o           (rank_o),
    .entry_key_o      (entry_key_o),
    .entry_uses_o     (entry_uses_o),
    .entries_in_use_o (entries_in_use_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic history_result_t apply_history_op(kind_e kind, logic [31:0] key,
                                                       logic [5:0] idx);
    history_result_t res;
    int              pos;
    int              dst;
    logic [31:0]     uses;
    res = NO_RESULT;
    pos = -1;
    for (int i = 0; i < table_used; i++) begin
      if (pos < 0 && table_key[i] == key) pos = i;
    end
    case (kind)
      KIND_ADD: begin
        res.key = key;
        if (pos >= 0) begin
          uses = table_uses[pos];
          if (uses != USE_MAX) uses = uses + 1;
          dst = pos;
          while (dst > 0 && table_uses[dst - 1] < uses) dst--;
          for (int i = pos; i > dst; i--) begin
            table_key[i]  = table_key[i - 1];
            table_uses[i] = table_uses[i - 1];
          end
          table_key[dst]  = key;
          table_uses[dst] = uses;
          res.rank = 6'(dst);
          res.uses = uses;
        end else if (table_used >= int'(DEPTH)) begin
          res.status = ST_FULL;
          full_seen++;
        end else begin
          table_key[table_used]  = key;
          table_uses[table_used] = 32'd1;
          res.rank = 6'(table_used);
          res.uses = 32'd1;
          table_used++;
        end
      end
      KIND_REMOVE: begin
        res.key = key;
        if (pos < 0) begin
          res.status = ST_NOT_FOUND;
          miss_seen++;
        end else begin
          res.rank = 6'(pos);
          res.uses = table_uses[pos];
          for (int i = pos; i < table_used - 1; i++) begin
            table_key[i]  = table_key[i + 1];
            table_uses[i] = table_uses[i + 1];
          end
          table_used--;
        end
      end
      KIND_READ: begin
        res.rank = idx;
        if (int'(idx) < table_used) begin
          res.key  = table_key[idx];
          res.uses = table_uses[idx];
        end else begin
          res.status = ST_RANGE;
          range_seen++;
        end
      end
      default: begin
      end
    endcase
    if (table_used > peak_used) peak_used = table_used;
    res.count = 7'(table_used);
    return res;
  endfunction

  task automatic pick_item(input traffic_e phase, output kind_e kind, output logic [31:0] key,
                           output logic [5:0] idx);
    int          roll;
    logic [31:0] present;
    logic [5:0]  probe_idx;
    roll      = $urandom_range(99);
    key       = $urandom();
    idx       = 6'($urandom_range(63));
    present   = (table_used == 0) ? key : table_key[$urandom_range(table_used - 1)];
    probe_idx = (table_used > 0 && $urandom_range(3) != 0) ?
                6'($urandom_range(table_used - 1)) : idx;
    kind      = KIND_IGNORE;
    if (roll >= 5) begin
      roll = $urandom_range(99);
      case (phase)
        PH_FILL: begin
          if (roll < 65) kind = KIND_ADD;
          else if (roll < 85) begin
            kind = KIND_ADD;
            key  = present;
          end else if (roll < 95) kind = KIND_READ;
          else begin
            kind = KIND_REMOVE;
            key  = present;
          end
        end
        PH_CHURN: begin
          if (roll < 50) begin
            kind = KIND_ADD;
            key  = present;
          end else if (roll < 62) kind = KIND_ADD;
          else if (roll < 80) kind = KIND_READ;
          else if (roll < 95) begin
            kind = KIND_REMOVE;
            key  = present;
          end else kind = KIND_REMOVE;
        end
        default: begin
          if (roll < 60) begin
            kind = KIND_REMOVE;
            key  = present;
          end else if (roll < 72) kind = KIND_REMOVE;
          else if (roll < 87) kind = KIND_READ;
          else begin
            kind = KIND_ADD;
            key  = present;
          end
        end
      endcase
      if (kind == KIND_READ) idx = probe_idx;
    end
  endtask

  task automatic send_item(input kind_e kind, input logic [31:0] key, input logic [5:0] idx,
                           input bit typed, input history_result_t want);
    history_result_t predicted;
    while (!steady && $urandom_range(99) < 24) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i     <= kind;
    key_i      <= key;
    index_i    <= idx;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    predicted = apply_history_op(kind, key, idx);
    expected_q.push_back(typed ? want : predicted);
    transactions_sent++;
  endtask

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("result %0d, %s is %0h, expected %0h",
                                results_checked, name, got, want));
    end
  endtask

  always @(posedge clk_i) begin
    out_ready_i <= steady || ($urandom_range(99) >= 24);
  end

  always @(posedge clk_i) begin
    history_result_t want;
    if ((in_valid_i && in_ready_o === 1'b1) || (out_valid_o === 1'b1 && out_ready_i)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (out_valid_o === 1'b1 && out_ready_i) begin
      results_checked++;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with no transaction pending",
                                  results_checked));
      end else begin
        want = expected_q.pop_front();
        check_field("status", 32'(status_o), 32'(want.status));
        check_field("rank", 32'(rank_o), 32'(want.rank));
        check_field("entry_key", entry_key_o, want.key);
        check_field("entry_uses", entry_uses_o, want.uses);
        check_field("entries_in_use", 32'(entries_in_use_o), 32'(want.count));
      end
    end
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("[%0t] watchdog: no transaction for %0d cycles, %0d results outstanding",
               $realtime, stall_cycles, expected_q.size());
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    kind_e       kind;
    logic [31:0] key;
    logic [5:0]  idx;
    traffic_e    phase;
    int          phase_left;
    int          random_sent;
    phase       = PH_DRAIN;
    phase_left  = 0;
    random_sent = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (int i = 0; i < $size(DIRECTED_ROWS); i++) begin
      send_item(DIRECTED_ROWS[i].kind, DIRECTED_ROWS[i].key, DIRECTED_ROWS[i].idx,
                DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
    end
    while (random_sent < RANDOM_ITEMS) begin
      if (phase_left <= 0) begin
        case (phase)
          PH_FILL: begin
            phase      = PH_CHURN;
            phase_left = $urandom_range(120, 60);
          end
          PH_CHURN: begin
            phase      = PH_DRAIN;
            phase_left = $urandom_range(110, 60);
          end
          default: begin
            phase      = PH_FILL;
            phase_left = $urandom_range(140, 110);
          end
        endcase
      end
      steady = (random_sent >= 300 && random_sent < 450);
      pick_item(phase, kind, key, idx);
      send_item(kind, key, idx, 1'b0, NO_RESULT);
      if (kind != KIND_IGNORE) begin
        random_sent++;
        phase_left--;
      end
    end
    steady = 1'b0;
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("Sent %0d transactions (%0d directed), checked %0d results; peak fill %0d of %0d.",
             transactions_sent, $size(DIRECTED_ROWS), results_checked, peak_used, DEPTH);
    $display("Adds refused on a full table: %0d, removes of absent keys: %0d, reads past end: %0d.",
             full_seen, miss_seen, range_seen);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
